// ----- src/rss_pkg.sv -----
`timescale 1ns / 1ps

package rss_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DEPTH_OUT_W = 7;

	typedef enum logic [1:0] {
		OPC_PUSH = 2'd0,
		OPC_POP  = 2'd1,
		OPC_SORT = 2'd2,
		OPC_NOP  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [31:0] id;
		logic        [63:0] tag;
		logic signed [31:0] qty;
	} rec_t;

	// one datapath micro-operation per cycle
	typedef enum logic [3:0] {
		OP_NONE      = 4'd0,
		OP_CAPTURE   = 4'd1,
		OP_PUSH      = 4'd2,
		OP_POP_RD    = 4'd3,
		OP_LOAD_MRD  = 4'd4,
		OP_LOAD_ZERO = 4'd5,
		OP_TOP_RD    = 4'd6,
		OP_SORT_RD   = 4'd7,
		OP_GRAB      = 4'd8,
		OP_MOVE      = 4'd9,
		OP_PUSH_AUX  = 4'd10,
		OP_DRAIN_RD  = 4'd11,
		OP_DRAIN_WR  = 4'd12
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t st;
	} dp_cmd_t;

	typedef struct packed {
		opcode_t opcode;
		logic    main_empty;
		logic    main_full;
		logic    aux_empty;
		logic    aux_gt;
		logic    out_busy;
	} dp_stat_t;

endpackage

// ----- src/rss_ctrl.sv -----
`timescale 1ns / 1ps

module rss_ctrl import rss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_EXEC  = 10'b00_0000_0010,
		ST_POPR  = 10'b00_0000_0100,
		ST_TOP   = 10'b00_0000_1000,
		ST_TOPR  = 10'b00_0001_0000,
		ST_SORT  = 10'b00_0010_0000,
		ST_GRAB  = 10'b00_0100_0000,
		ST_CMP   = 10'b00_1000_0000,
		ST_DRAIN = 10'b01_0000_0000,
		ST_DWR   = 10'b10_0000_0000
	} state_t;

	state_t  state_q, state_d;
	status_t st_q, st_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd.op  = OP_NONE;
		cmd.st  = STAT_OK;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (stat.opcode)
					OPC_PUSH: begin
						if (stat.main_full) begin
							st_d    = STAT_FULL;
							state_d = ST_TOP;
						end else if (!stat.out_busy) begin
							cmd.op  = OP_PUSH;
							cmd.st  = STAT_OK;
							state_d = ST_IDLE;
						end
					end
					OPC_POP: begin
						if (!stat.main_empty) begin
							cmd.op  = OP_POP_RD;
							state_d = ST_POPR;
						end else if (!stat.out_busy) begin
							cmd.op  = OP_LOAD_ZERO;
							cmd.st  = STAT_EMPTY;
							state_d = ST_IDLE;
						end
					end
					OPC_SORT: begin
						st_d    = STAT_OK;
						state_d = ST_SORT;
					end
					default: begin
						st_d    = STAT_OK;
						state_d = ST_TOP;
					end
				endcase
			end
			ST_POPR: begin
				if (!stat.out_busy) begin
					cmd.op  = OP_LOAD_MRD;
					cmd.st  = STAT_OK;
					state_d = ST_IDLE;
				end
			end
			ST_TOP: begin
				if (!stat.main_empty) begin
					cmd.op  = OP_TOP_RD;
					state_d = ST_TOPR;
				end else if (!stat.out_busy) begin
					cmd.op  = OP_LOAD_ZERO;
					cmd.st  = st_q;
					state_d = ST_IDLE;
				end
			end
			ST_TOPR: begin
				if (!stat.out_busy) begin
					cmd.op  = OP_LOAD_MRD;
					cmd.st  = st_q;
					state_d = ST_IDLE;
				end
			end
			ST_SORT: begin
				if (stat.main_empty) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.op  = OP_SORT_RD;
					state_d = ST_GRAB;
				end
			end
			ST_GRAB: begin
				cmd.op  = OP_GRAB;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				// strict compare keeps equal keys in their order
				if (!stat.aux_empty && stat.aux_gt) begin
					cmd.op = OP_MOVE;
				end else begin
					cmd.op  = OP_PUSH_AUX;
					state_d = ST_SORT;
				end
			end
			ST_DRAIN: begin
				if (stat.aux_empty) begin
					state_d = ST_TOP;
				end else begin
					cmd.op  = OP_DRAIN_RD;
					state_d = ST_DWR;
				end
			end
			ST_DWR: begin
				cmd.op  = OP_DRAIN_WR;
				state_d = ST_DRAIN;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			st_q    <= STAT_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

endmodule

// ----- src/rss_dp.sv -----
`timescale 1ns / 1ps

module rss_dp import rss_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_cmd_t                       cmd,
	output dp_stat_t                      stat,
	input  logic                    [1:0] opcode,
	input  logic signed            [31:0] item_id,
	input  logic                   [63:0] name_tag,
	input  logic signed            [31:0] quantity,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed            [31:0] out_id,
	output logic                   [63:0] out_name,
	output logic signed            [31:0] out_qty,
	output logic                    [1:0] status,
	output logic [DEPTH_OUT_W-1:0]        depth_now
);

	rec_t m_mem [STACK_DEPTH];
	rec_t a_mem [STACK_DEPTH];

	rec_t    cmd_rec_q;
	opcode_t cmd_op_q;
	rec_t    r_q;
	rec_t    m_rdata_q, a_rdata_q;

	logic [CNT_W-1:0] mc_q, ac_q;
	logic [CNT_W-1:0] mc_inc, mc_dec, ac_inc, ac_dec, ac_dec2;

	logic              m_we, m_re, a_we, a_re;
	logic [ADDR_W-1:0] m_waddr, m_raddr, a_waddr, a_raddr;
	rec_t              m_wdata;

	logic                   out_valid_q;
	rec_t                   out_rec_q;
	status_t                out_st_q;
	logic [DEPTH_OUT_W-1:0] out_depth_q;
	logic                   load_out;

	assign mc_inc  = mc_q + 1'b1;
	assign mc_dec  = mc_q - 1'b1;
	assign ac_inc  = ac_q + 1'b1;
	assign ac_dec  = ac_q - 1'b1;
	assign ac_dec2 = ac_q - CNT_W'(2);

	assign stat.opcode     = cmd_op_q;
	assign stat.main_empty = (mc_q == '0);
	assign stat.main_full  = (mc_q == CNT_W'(STACK_DEPTH));
	assign stat.aux_empty  = (ac_q == '0);
	assign stat.aux_gt     = ($signed(a_rdata_q.qty) > $signed(r_q.qty));
	assign stat.out_busy   = out_valid_q && !out_ready;

	always_comb begin
		m_we    = 1'b0;
		m_re    = 1'b0;
		a_we    = 1'b0;
		a_re    = 1'b0;
		m_waddr = mc_q[ADDR_W-1:0];
		m_raddr = mc_dec[ADDR_W-1:0];
		m_wdata = cmd_rec_q;
		a_waddr = ac_q[ADDR_W-1:0];
		a_raddr = ac_dec[ADDR_W-1:0];
		case (cmd.op)
			OP_PUSH: begin
				m_we = 1'b1;
			end
			OP_POP_RD, OP_TOP_RD: begin
				m_re = 1'b1;
			end
			OP_SORT_RD: begin
				m_re = 1'b1;
				a_re = (ac_q != '0);
			end
			OP_MOVE: begin
				// move aux top down and fetch the next aux top
				m_we    = 1'b1;
				m_wdata = a_rdata_q;
				a_re    = (ac_q > CNT_W'(1));
				a_raddr = ac_dec2[ADDR_W-1:0];
			end
			OP_PUSH_AUX: begin
				a_we = 1'b1;
			end
			OP_DRAIN_RD: begin
				a_re = 1'b1;
			end
			OP_DRAIN_WR: begin
				m_we    = 1'b1;
				m_wdata = a_rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (m_we) begin
			m_mem[m_waddr] <= m_wdata;
		end
		if (m_re) begin
			m_rdata_q <= m_mem[m_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[a_waddr] <= r_q;
		end
		if (a_re) begin
			a_rdata_q <= a_mem[a_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q <= '0;
			ac_q <= '0;
		end else begin
			case (cmd.op)
				OP_PUSH, OP_DRAIN_WR: begin
					mc_q <= mc_inc;
				end
				OP_POP_RD, OP_SORT_RD: begin
					mc_q <= mc_dec;
				end
				OP_MOVE: begin
					mc_q <= mc_inc;
					ac_q <= ac_dec;
				end
				OP_PUSH_AUX: begin
					ac_q <= ac_inc;
				end
				OP_DRAIN_RD: begin
					ac_q <= ac_dec;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CAPTURE) begin
			cmd_op_q      <= opcode_t'(opcode);
			cmd_rec_q.id  <= item_id;
			cmd_rec_q.tag <= name_tag;
			cmd_rec_q.qty <= quantity;
		end
		if (cmd.op == OP_GRAB) begin
			r_q <= m_rdata_q;
		end
	end

	assign load_out = (cmd.op == OP_PUSH) || (cmd.op == OP_LOAD_MRD) ||
		(cmd.op == OP_LOAD_ZERO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_st_q <= cmd.st;
			case (cmd.op)
				OP_PUSH: begin
					out_rec_q   <= cmd_rec_q;
					out_depth_q <= DEPTH_OUT_W'(mc_inc);
				end
				OP_LOAD_MRD: begin
					out_rec_q   <= m_rdata_q;
					out_depth_q <= DEPTH_OUT_W'(mc_q);
				end
				default: begin
					out_rec_q   <= '0;
					out_depth_q <= DEPTH_OUT_W'(mc_q);
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_id    = out_rec_q.id;
	assign out_name  = out_rec_q.tag;
	assign out_qty   = out_rec_q.qty;
	assign status    = out_st_q;
	assign depth_now = out_depth_q;

endmodule

// ----- src/record_stack_with_stable_sort_unit.sv -----
`timescale 1ns / 1ps
// A new item is accepted only in idle, at the same edge that can first take the previous result;
// a result still held by out_ready low delays the next load, and so the next accept.
// Reset: arst_n clears the controller, both counts and the output valid; stores are not cleared.
module record_stack_with_stable_sort_unit import rss_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                    [1:0] opcode,
	input  logic signed            [31:0] item_id,
	input  logic                   [63:0] name_tag,
	input  logic signed            [31:0] quantity,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed            [31:0] out_id,
	output logic                   [63:0] out_name,
	output logic signed            [31:0] out_qty,
	output logic                    [1:0] status,
	output logic [DEPTH_OUT_W-1:0]        depth_now
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rss_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.opcode    (opcode),
		.item_id   (item_id),
		.name_tag  (name_tag),
		.quantity  (quantity),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_id    (out_id),
		.out_name  (out_name),
		.out_qty   (out_qty),
		.status    (status),
		.depth_now (depth_now)
	);

	a_no_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.op == OP_PUSH) || (cmd.op == OP_LOAD_MRD) || (cmd.op == OP_LOAD_ZERO))
		|-> !stat.out_busy)
		else $error("result loaded while output still held");

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("new item taken before the previous one finished");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STAT_EMPTY)) |->
		((depth_now == '0) && (out_id == '0) && (out_qty == '0)))
		else $error("empty status with nonzero record or depth");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STAT_FULL)) |-> (depth_now == DEPTH_OUT_W'(STACK_DEPTH)))
		else $error("full status with wrong depth");

endmodule
